FILE: rtl/rad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rad_pkg
// shared types, register codes and chunk ids for the avi chunk demultiplexer
// ----------------------------------------------------------------------------
package rad_pkg;

  // audio ring depth and slot counter width
  localparam int RING_SLOTS = 100;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int AUDIO_SLOT_W = 7;

  // configuration port widths
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VIDEO_FRAMES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BITS       = 8'd3;

  // register reset values
  localparam logic [7:0]  MAX_VIDEO_FRAMES_RST = 8'd8;
  localparam logic [15:0] FRAME_WIDTH_RST      = 16'd0;
  localparam logic [15:0] FRAME_HEIGHT_RST     = 16'd0;
  localparam logic [5:0]  PIXEL_BITS_RST       = 6'd16;

  // fourcc codes, first stream byte in the low byte
  localparam logic [31:0] FCC_LIST = 32'h5453494C;
  localparam logic [31:0] FCC_00DB = 32'h62643030;
  localparam logic [31:0] FCC_00DC = 32'h63643030;
  localparam logic [31:0] FCC_00WB = 32'h62773030;
  localparam logic [31:0] FCC_01WB = 32'h62773130;

  // bytes skipped after a list header
  localparam logic [31:0] LIST_SKIP = 32'd4;

  // chunk kind codes
  localparam logic KIND_VIDEO = 1'b0;
  localparam logic KIND_AUDIO = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
  } in_item_t;

  typedef struct packed {
    logic                    chunk_kind;
    logic [31:0]             chunk_offset;
    logic [31:0]             chunk_length;
    logic [AUDIO_SLOT_W-1:0] audio_slot;
    logic [15:0]             out_width;
    logic [15:0]             out_height;
    logic [5:0]              out_bits;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_video_frames;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [5:0]  pixel_bits;
  } cfg_regs_t;

endpackage
`default_nettype wire

FILE: rtl/rad_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rad_parser
// per-byte chunk header gathering, skip counting and chunk classification
// ----------------------------------------------------------------------------
module rad_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_accept,
  input  wire rad_pkg::in_item_t  item,
  input  wire rad_pkg::cfg_regs_t cfg,
  output logic                    res_valid,
  output rad_pkg::out_item_t      res_item
);

  localparam int SLOT_EXT_W =
    (rad_pkg::SLOT_W > rad_pkg::AUDIO_SLOT_W) ? rad_pkg::SLOT_W : rad_pkg::AUDIO_SLOT_W;

  logic [31:0] off_r, off_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [55:0] hdr_r, hdr_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  vc_r, vc_nxt;
  logic        done_r, done_nxt;
  logic [rad_pkg::SLOT_W-1:0] slot_r, slot_nxt;

  logic [31:0] off_cur, skip_cur, fcc, size;
  logic [2:0]  cnt_cur;
  logic [7:0]  vc_cur;
  logic        done_cur, stopped;
  logic [SLOT_EXT_W-1:0] slot_ext;

  assign slot_ext = SLOT_EXT_W'(slot_r);
  assign fcc      = hdr_r[31:0];
  assign size     = {item.data_byte, hdr_r[55:32]};

  always_comb begin
    // buffer start clears the per-buffer state before the byte is handled
    off_cur  = item.buffer_start ? 32'd0 : off_r;
    cnt_cur  = item.buffer_start ? 3'd0  : cnt_r;
    skip_cur = item.buffer_start ? 32'd0 : skip_r;
    vc_cur   = item.buffer_start ? 8'd0  : vc_r;
    done_cur = item.buffer_start ? 1'b0  : done_r;
    stopped  = done_cur || (vc_cur >= cfg.max_video_frames);

    off_nxt   = off_cur + 32'd1;
    cnt_nxt   = cnt_cur;
    hdr_nxt   = hdr_r;
    skip_nxt  = skip_cur;
    vc_nxt    = vc_cur;
    done_nxt  = done_cur;
    slot_nxt  = slot_r;
    res_valid = 1'b0;
    res_item  = '0;

    if (!stopped) begin
      if (skip_cur != 32'd0) begin
        skip_nxt = skip_cur - 32'd1;
      end else if (cnt_cur != 3'd7) begin
        hdr_nxt = {item.data_byte, hdr_r[55:8]};
        cnt_nxt = cnt_cur + 3'd1;
      end else begin
        // eighth header byte: classify the chunk
        cnt_nxt = 3'd0;
        if (fcc == rad_pkg::FCC_LIST) begin
          skip_nxt = rad_pkg::LIST_SKIP;
        end else if (fcc == rad_pkg::FCC_00DB || fcc == rad_pkg::FCC_00DC) begin
          res_valid             = 1'b1;
          res_item.chunk_kind   = rad_pkg::KIND_VIDEO;
          res_item.chunk_offset = off_cur + 32'd1;
          res_item.chunk_length = size;
          res_item.out_width    = cfg.frame_width;
          res_item.out_height   = cfg.frame_height;
          res_item.out_bits     = cfg.pixel_bits;
          skip_nxt              = size;
          vc_nxt                = vc_cur + 8'd1;
          done_nxt              = (vc_nxt >= cfg.max_video_frames);
        end else if (fcc == rad_pkg::FCC_00WB || fcc == rad_pkg::FCC_01WB) begin
          res_valid             = 1'b1;
          res_item.chunk_kind   = rad_pkg::KIND_AUDIO;
          res_item.chunk_offset = off_cur - 32'd7;
          res_item.chunk_length = size;
          res_item.audio_slot   = slot_ext[rad_pkg::AUDIO_SLOT_W-1:0];
          skip_nxt              = size;
          if (slot_r == rad_pkg::SLOT_W'(rad_pkg::RING_SLOTS - 1)) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + rad_pkg::SLOT_W'(1);
          end
        end else begin
          skip_nxt = size;
        end
      end
    end

    if (!byte_accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      cnt_r  <= '0;
      skip_r <= '0;
      vc_r   <= '0;
      done_r <= 1'b0;
      slot_r <= '0;
    end else if (byte_accept) begin
      off_r  <= off_nxt;
      cnt_r  <= cnt_nxt;
      skip_r <= skip_nxt;
      vc_r   <= vc_nxt;
      done_r <= done_nxt;
      slot_r <= slot_nxt;
    end
  end

  // header bytes need no reset: the count decides which are live
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/riff_avi_chunk_demux.sv
`default_nettype none
// ----------------------------------------------------------------------------
// riff_avi_chunk_demux
// avi movie data demultiplexer: reports video and audio chunks of a byte stream
// ----------------------------------------------------------------------------
// a result is registered in out_item, or in the skid entry if out_item is full
// throughput: one byte item per cycle; the parser updates header/skip state per byte,
//   and input stalls only while two results wait
// reset (rst_n low, synchronous): parse state, offset, ring slot and output queue
//   cleared; max_video_frames 8, frame_width 0, frame_height 0, pixel_bits 16
module riff_avi_chunk_demux (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rad_pkg::in_item_t               in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rad_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  rad_pkg::cfg_regs_t cfg_r;

  // parser result for the byte accepted this cycle
  logic               res_valid;
  rad_pkg::out_item_t res_item;

  // two-entry output queue: out register plus skid entry
  logic               out_valid_r;
  rad_pkg::out_item_t out_item_r;
  logic               skid_valid_r;
  rad_pkg::out_item_t skid_item_r;

  logic in_accept, out_pop;

  assign cfg_ready = 1'b1;
  // a new item is taken as long as the skid entry is free
  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;
  assign out_pop   = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // register writes, masked to each register's width; unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_video_frames <= rad_pkg::MAX_VIDEO_FRAMES_RST;
      cfg_r.frame_width      <= rad_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height     <= rad_pkg::FRAME_HEIGHT_RST;
      cfg_r.pixel_bits       <= rad_pkg::PIXEL_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rad_pkg::REG_MAX_VIDEO_FRAMES: cfg_r.max_video_frames <= cfg_data[7:0];
        rad_pkg::REG_FRAME_WIDTH:      cfg_r.frame_width      <= cfg_data[15:0];
        rad_pkg::REG_FRAME_HEIGHT:     cfg_r.frame_height     <= cfg_data[15:0];
        rad_pkg::REG_PIXEL_BITS:       cfg_r.pixel_bits       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  rad_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .item        (in_item),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

  // output queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid_r) begin
          // skid moves up; no new result can arrive while skid is full
          skid_valid_r <= 1'b0;
        end else if (!res_valid) begin
          out_valid_r <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  // output queue payload
  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (res_valid) begin
        out_item_r <= res_item;
      end
    end else if (res_valid) begin
      if (out_valid_r) begin
        skid_item_r <= res_item;
      end else begin
        out_item_r <= res_item;
      end
    end
  end

  // skid entry is only ever used behind a full out register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while out register empty");

  // a result only comes from an accepted byte
  a_res_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_accept)
    else $error("parser result without an accepted item");

  // taking a result with the skid full leaves the skid result showing
  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && skid_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("skid result lost on output pop");

  // audio results carry no frame geometry
  a_audio_no_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.chunk_kind == rad_pkg::KIND_AUDIO) |->
      (out_item_r.out_width == 16'd0 && out_item_r.out_height == 16'd0 &&
       out_item_r.out_bits == 6'd0))
    else $error("audio result with frame geometry");

endmodule
`default_nettype wire

FILE: sim/riff_avi_chunk_demux_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_avi_chunk_demux_tb
// feeds riff movie data byte streams (video, audio, list and unknown chunks,
// truncated and broken headers, noise) through the demultiplexer under random
// idling on both channels, predicts every chunk report in a tracker class and
// compares each reported item field by field across several register settings
// ----------------------------------------------------------------------------
class chunk_tracker;
  rad_pkg::cfg_regs_t   regs;
  int                   hdr_count;
  logic [63:0]          hdr;
  logic [31:0]          skip_left;
  logic [31:0]          offset;
  int                   video_count;
  int                   slot;
  bit                   done;
  rad_pkg::out_item_t   expected_chunks[$];
  int                   errors;
  int                   audio_count;

  function new();
    regs.max_video_frames = rad_pkg::MAX_VIDEO_FRAMES_RST;
    regs.frame_width      = rad_pkg::FRAME_WIDTH_RST;
    regs.frame_height     = rad_pkg::FRAME_HEIGHT_RST;
    regs.pixel_bits       = rad_pkg::PIXEL_BITS_RST;
    slot        = 0;
    errors      = 0;
    audio_count = 0;
    clear_buffer();
  endfunction

  function void clear_buffer();
    hdr_count   = 0;
    hdr         = '0;
    skip_left   = '0;
    offset      = '0;
    video_count = 0;
    done        = 1'b0;
  endfunction

  function void set_reg(logic [rad_pkg::CFG_INDEX_W-1:0] idx,
                        logic [rad_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rad_pkg::REG_MAX_VIDEO_FRAMES: regs.max_video_frames = data[7:0];
      rad_pkg::REG_FRAME_WIDTH:      regs.frame_width      = data[15:0];
      rad_pkg::REG_FRAME_HEIGHT:     regs.frame_height     = data[15:0];
      rad_pkg::REG_PIXEL_BITS:       regs.pixel_bits       = data[5:0];
      default: ;
    endcase
  endfunction

  function bit stopped();
    return done || (video_count >= int'(regs.max_video_frames));
  endfunction

  function int pending();
    return expected_chunks.size();
  endfunction

  // returns 1 when the byte got past the stop check
  function bit note_byte(rad_pkg::in_item_t it);
    logic [31:0]        here;
    logic [31:0]        fcc;
    logic [31:0]        chunk_len;
    rad_pkg::out_item_t want;
    if (it.buffer_start) clear_buffer();
    here   = offset;
    offset = offset + 32'd1;
    if (stopped()) return 1'b0;
    if (skip_left != 32'd0) begin
      skip_left = skip_left - 32'd1;
      return 1'b1;
    end
    hdr[8*hdr_count +: 8] = it.data_byte;
    hdr_count++;
    if (hdr_count < 8) return 1'b1;
    fcc       = hdr[31:0];
    chunk_len = hdr[63:32];
    hdr_count = 0;
    hdr       = '0;
    want      = '0;
    if (fcc == rad_pkg::FCC_LIST) begin
      skip_left = rad_pkg::LIST_SKIP;
    end else if (fcc == rad_pkg::FCC_00DB || fcc == rad_pkg::FCC_00DC) begin
      // video reports the payload start
      want.chunk_kind   = rad_pkg::KIND_VIDEO;
      want.chunk_offset = here + 32'd1;
      want.chunk_length = chunk_len;
      want.out_width    = regs.frame_width;
      want.out_height   = regs.frame_height;
      want.out_bits     = regs.pixel_bits;
      expected_chunks.push_back(want);
      skip_left = chunk_len;
      video_count++;
      if (video_count >= int'(regs.max_video_frames)) done = 1'b1;
    end else if (fcc == rad_pkg::FCC_00WB || fcc == rad_pkg::FCC_01WB) begin
      // audio reports the header start
      want.chunk_kind   = rad_pkg::KIND_AUDIO;
      want.chunk_offset = here - 32'd7;
      want.chunk_length = chunk_len;
      want.audio_slot   = slot[rad_pkg::AUDIO_SLOT_W-1:0];
      expected_chunks.push_back(want);
      audio_count++;
      skip_left = chunk_len;
      slot++;
      if (slot >= rad_pkg::RING_SLOTS) slot = 0;
    end else begin
      skip_left = chunk_len;
    end
    return 1'b1;
  endfunction

  function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_chunk(rad_pkg::out_item_t got);
    rad_pkg::out_item_t want;
    if (expected_chunks.size() == 0) begin
      $error("unexpected chunk: kind %0d offset %0d length %0d",
             got.chunk_kind, got.chunk_offset, got.chunk_length);
      errors++;
      return;
    end
    want = expected_chunks.pop_front();
    cmp_field("chunk_kind",   32'(want.chunk_kind),   32'(got.chunk_kind));
    cmp_field("chunk_offset", want.chunk_offset,      got.chunk_offset);
    cmp_field("chunk_length", want.chunk_length,      got.chunk_length);
    cmp_field("audio_slot",   32'(want.audio_slot),   32'(got.audio_slot));
    cmp_field("out_width",    32'(want.out_width),    32'(got.out_width));
    cmp_field("out_height",   32'(want.out_height),   32'(got.out_height));
    cmp_field("out_bits",     32'(want.out_bits),     32'(got.out_bits));
  endfunction

  function void report_leftover();
    if (expected_chunks.size() != 0) begin
      $error("%0d chunk reports never arrived", expected_chunks.size());
      errors += expected_chunks.size();
    end
  endfunction
endclass

module riff_avi_chunk_demux_tb;

  // hard stop on item count in case a phase never reaches its quota
  localparam int ITEM_CAP = 6000;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  rad_pkg::in_item_t               in_item   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  rad_pkg::out_item_t              out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rad_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rad_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  chunk_tracker chunks;
  int           live_items   = 0;
  int           sent_items   = 0;
  bit           fresh_buffer = 1'b0;
  bit           calm_tx      = 1'b0;
  int           stall_left   = 0;
  int           calm_left    = 0;

  always #4 clk = ~clk;

  riff_avi_chunk_demux i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result side back-pressure: mostly ready, short and long stalls,
  // and now and then a calm stretch with no stalls at all
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      out_ready <= 1'b1;
      calm_left = calm_left - 1;
    end else if (r < 3) begin
      out_ready <= 1'b1;
      calm_left = $urandom_range(50, 200);
    end else if (r < 85) begin
      out_ready <= 1'b1;
    end else if (r < 97) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(15, 50);
    end
  end

  // every accepted report goes to the tracker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) chunks.check_chunk(out_item);
  end

  // sender gap before an item: mostly none, some short, a few long
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_tx) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high between back-to-back items, so it is only touched on change
  task automatic send_byte(input logic [7:0] data, input logic bs);
    int                gap;
    rad_pkg::in_item_t it;
    gap = tx_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte    = data;
    it.buffer_start = bs;
    in_item <= it;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (chunks.note_byte(it)) live_items++;
  endtask

  // called before any wait that is not a send
  task automatic in_idle();
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic drain();
    in_idle();
    while (chunks.pending() != 0) @(posedge clk);
    // items that make no report may still be in flight
    repeat (8) @(posedge clk);
  endtask

  // little-endian, buffer_start only on the first byte
  task automatic send_word(input logic [31:0] w, input logic bs);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], bs && (i == 0));
  endtask

  task automatic send_chunk(input logic [31:0] fcc, input logic [31:0] chunk_len,
                            input int payload, input logic bs);
    send_word(fcc, bs);
    send_word(chunk_len, 1'b0);
    repeat (payload) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // small sizes dominate, extremes now and then
  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 16);
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(41, 300);
    endcase
  endfunction

  // audio heavy so the slot ring wraps; unknown ids include near misses
  function automatic logic [31:0] pick_fourcc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return rad_pkg::FCC_LIST;
    if (r < 12) return rad_pkg::FCC_00DB;
    if (r < 20) return rad_pkg::FCC_00DC;
    if (r < 55) return rad_pkg::FCC_00WB;
    if (r < 90) return rad_pkg::FCC_01WB;
    if (r < 95) return $urandom;
    return rad_pkg::FCC_00WB ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic send_well_formed(input logic bs);
    logic [31:0] fcc;
    logic [31:0] chunk_len;
    fcc       = pick_fourcc();
    chunk_len = pick_size();
    if (fcc == rad_pkg::FCC_LIST) begin
      // list size field is never used
      send_chunk(fcc, $urandom, 4, bs);
    end else if (chunk_len <= 32'd40) begin
      send_chunk(fcc, chunk_len, int'(chunk_len), bs);
    end else begin
      // big payloads are cut short and the next buffer takes over
      send_chunk(fcc, chunk_len, $urandom_range(0, 10), bs);
      fresh_buffer = 1'b1;
    end
  endtask

  task automatic run_random(input int quota, input bit want_wrap);
    int          start;
    int          r;
    int          n;
    logic        bs;
    logic [63:0] partial;
    start        = live_items;
    fresh_buffer = 1'b1;
    while ((live_items - start < quota || (want_wrap && chunks.audio_count < 105))
           && sent_items < ITEM_CAP) begin
      calm_tx = ($urandom_range(0, 9) == 0);
      if (chunks.stopped() || $urandom_range(0, 11) == 0) fresh_buffer = 1'b1;
      bs = fresh_buffer;
      r  = $urandom_range(0, 99);
      if (r < 90) begin
        fresh_buffer = 1'b0;
        send_well_formed(bs);
      end else if (r < 94) begin
        // raw noise, then resync on a new buffer
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        fresh_buffer = 1'b1;
      end else if (r < 98) begin
        // header cut off part way
        fresh_buffer = 1'b0;
        partial = {pick_size(), pick_fourcc()};
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) send_byte(partial[8*i +: 8], bs && (i == 0));
        fresh_buffer = 1'b1;
      end else begin
        // hold off until every report is out
        drain();
      end
    end
    calm_tx = 1'b0;
  endtask

  task automatic reg_write(input logic [rad_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rad_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    if (!cfg_valid) cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    chunks.set_reg(idx, data);
  endtask

  // writes only on an idle block; junk adds a write to an unused index
  task automatic set_config(input logic [rad_pkg::CFG_DATA_W-1:0] max_frames,
                            input logic [rad_pkg::CFG_DATA_W-1:0] width,
                            input logic [rad_pkg::CFG_DATA_W-1:0] height,
                            input logic [rad_pkg::CFG_DATA_W-1:0] bits,
                            input bit junk);
    drain();
    reg_write(rad_pkg::REG_MAX_VIDEO_FRAMES, max_frames);
    reg_write(rad_pkg::REG_FRAME_WIDTH, width);
    reg_write(rad_pkg::REG_FRAME_HEIGHT, height);
    reg_write(rad_pkg::REG_PIXEL_BITS, bits);
    if (junk) reg_write(8'($urandom_range(4, 255)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    chunks = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: video and audio with empty payloads, then a list header
    // with an all-ones size field and its four skipped bytes
    send_chunk(rad_pkg::FCC_00DC, 32'd0, 0, 1'b1);
    send_chunk(rad_pkg::FCC_01WB, 32'd0, 0, 1'b0);
    send_chunk(rad_pkg::FCC_LIST, 32'hFFFF_FFFF, 4, 1'b0);

    // one frame per buffer, width and height at their top end
    set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd32, 1'b0);
    run_random(250, 1'b0);

    // widest frame count, geometry all zero
    set_config(16'd255, 16'd0, 16'd0, 16'd0, 1'b0);
    run_random(250, 1'b0);

    // zero frames: every byte only advances the offset
    set_config(16'd0, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 32)), 1'b1);
    repeat (40) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);

    // random values with junk in the bits above the frame count and pixel bits registers
    set_config({8'($urandom), 8'($urandom_range(2, 6))}, 16'($urandom), 16'($urandom),
               {10'($urandom), 6'($urandom)}, 1'b0);
    run_random(350, 1'b0);

    // last setting runs on until the audio slot has wrapped
    set_config(16'd3, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 32)), 1'b0);
    run_random(350, 1'b1);

    drain();
    repeat (16) @(posedge clk);
    chunks.report_leftover();
    if (chunks.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
